// ===== hdl/tnorla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnorla_pkg
// Shared constants, state encodings and control structs for the telnet
// option refuser and line assembler.
// ----------------------------------------------------------------------------
package tnorla_pkg;

    localparam int LINE_LENGTH = 64;
    localparam int IDX_W       = $clog2(LINE_LENGTH);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(LINE_LENGTH - 1);

    localparam logic [7:0] CH_NL   = 8'h0a;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] REPLY_PAD = 8'h00;

    localparam logic KIND_LINE  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    typedef enum logic [2:0] {
        PS_NORMAL = 3'd0,
        PS_IAC    = 3'd1,
        PS_WILL   = 3'd2,
        PS_WONT   = 3'd3,
        PS_DO     = 3'd4,
        PS_DONT   = 3'd5
    } parse_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REPLY,
        ST_NL,
        ST_LINE_RD,
        ST_LINE_LD
    } ctrl_state_t;

    typedef enum logic [1:0] {
        OUT_LINE,
        OUT_REPLY,
        OUT_NL
    } out_sel_t;

    typedef enum logic [1:0] {
        RS_IAC  = 2'd0,
        RS_CODE = 2'd1,
        RS_OPT  = 2'd2,
        RS_END  = 2'd3
    } rep_step_t;

    typedef struct packed {
        logic     wr_byte;    // write rx byte into the line store
        logic     fill_clr;   // line ends: latch length, restart fill
        logic     fill_inc;
        logic     opt_load;   // latch option byte and refusal code
        logic     code_dont;  // 1: refuse with DONT, 0: refuse with WONT
        logic     rd_issue;   // read store at the read pointer
        logic     out_load;   // load the output word register
        out_sel_t out_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_iac;
        logic is_will;
        logic is_wont;
        logic is_do;
        logic is_dont;
        logic is_cr;
        logic is_nl;
        logic fill_last;
        logic fill_zero;
        logic rd_last;
        logic rep_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/tnorla_rx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnorla_rx_if
// Received byte channel: valid/ready handshake carrying one telnet byte.
// ----------------------------------------------------------------------------
interface tnorla_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/tnorla_tx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnorla_tx_if
// Result channel: valid/ready handshake carrying kind, byte and last mark.
// ----------------------------------------------------------------------------
interface tnorla_tx_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output kind, output out_byte, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

// ===== hdl/telnet_option_refuser_line_assembler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_option_refuser_line_assembler_core
// Telnet IAC parser that refuses every option and assembles command lines.
// ----------------------------------------------------------------------------
// Usage:
//   rx: one received telnet byte per word (valid/ready). Bytes are taken in
//       one cycle each while the sequencer is idle.
//   tx: result words {kind, out_byte, last}. kind 1 is an option refusal
//       (IAC DONT x 0 or IAC WONT x 0, last on the fourth), kind 0 is a
//       completed line, last on its final byte. An empty line gives a
//       single newline word.
//   Timing: a byte that produces nothing is taken every cycle. A refusal
//       holds rx off after the option byte until its reply run is out; a
//       line holds it off until all its stored bytes are out, since each
//       byte is one read of the single-port line store followed by one
//       output register load. Line store depth is LINE_LENGTH; the byte
//       landing in its last slot closes the line and is dropped.
//   Reset: parser returns to the normal data state, line fill is cleared,
//       tx is empty. The store contents are not cleared.
//   Stall: tx has a one-word output register; while it is full and not
//       taken, emission pauses and rx stays blocked until the run is out.
// ----------------------------------------------------------------------------
module telnet_option_refuser_line_assembler_core
(
    input  logic       clk,
    input  logic       rst_n,
    tnorla_rx_if.sink  rx,
    tnorla_tx_if.source tx
);

    tnorla_pkg::ctrl_cmd_t  cmd;
    tnorla_pkg::dp_status_t sts;

    tnorla_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tnorla_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (rx.rx_byte),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (tx.ready),
        .out_valid (tx.valid),
        .out_kind  (tx.kind),
        .out_byte  (tx.out_byte),
        .out_last  (tx.last)
    );

endmodule

// ===== hdl/tnorla_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnorla_dp
// Datapath: line store, fill and read pointers, reply latch and the
// registered output word.
// ----------------------------------------------------------------------------
module tnorla_dp
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            rx_byte,
    input  tnorla_pkg::ctrl_cmd_t cmd,
    output tnorla_pkg::dp_status_t sts,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  out_kind,
    output logic [7:0]            out_byte,
    output logic                  out_last
);

    logic [7:0] store_mem [tnorla_pkg::LINE_LENGTH];
    logic [7:0] rd_data_reg;

    logic [tnorla_pkg::IDX_W-1:0] fill_reg;
    logic [tnorla_pkg::IDX_W-1:0] end_reg;
    logic [tnorla_pkg::IDX_W-1:0] rd_idx_reg;
    logic [7:0]                   opt_reg;
    logic [7:0]                   code_reg;
    tnorla_pkg::rep_step_t        rep_reg;

    logic       out_valid_reg;
    logic       out_kind_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    logic       next_kind;
    logic [7:0] next_byte;
    logic       next_last;
    logic [7:0] rep_byte;

    always_comb
    begin
        sts.is_iac    = (rx_byte == tnorla_pkg::TN_IAC);
        sts.is_will   = (rx_byte == tnorla_pkg::TN_WILL);
        sts.is_wont   = (rx_byte == tnorla_pkg::TN_WONT);
        sts.is_do     = (rx_byte == tnorla_pkg::TN_DO);
        sts.is_dont   = (rx_byte == tnorla_pkg::TN_DONT);
        sts.is_cr     = (rx_byte == tnorla_pkg::CH_CR);
        sts.is_nl     = (rx_byte == tnorla_pkg::CH_NL);
        sts.fill_last = (fill_reg == tnorla_pkg::LAST_SLOT);
        sts.fill_zero = (fill_reg == '0);
        sts.rd_last   = ((rd_idx_reg + tnorla_pkg::IDX_W'(1)) == end_reg);
        sts.rep_last  = (rep_reg == tnorla_pkg::RS_END);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        case (rep_reg)
            tnorla_pkg::RS_IAC:  rep_byte = tnorla_pkg::TN_IAC;
            tnorla_pkg::RS_CODE: rep_byte = code_reg;
            tnorla_pkg::RS_OPT:  rep_byte = opt_reg;
            tnorla_pkg::RS_END:  rep_byte = tnorla_pkg::REPLY_PAD;
            default:             rep_byte = tnorla_pkg::REPLY_PAD;
        endcase
    end

    always_comb
    begin
        case (cmd.out_sel)
            tnorla_pkg::OUT_REPLY:
            begin
                next_kind = tnorla_pkg::KIND_REPLY;
                next_byte = rep_byte;
                next_last = (rep_reg == tnorla_pkg::RS_END);
            end
            tnorla_pkg::OUT_NL:
            begin
                next_kind = tnorla_pkg::KIND_LINE;
                next_byte = tnorla_pkg::CH_NL;
                next_last = 1'b1;
            end
            default:
            begin
                next_kind = tnorla_pkg::KIND_LINE;
                next_byte = rd_data_reg;
                next_last = sts.rd_last;
            end
        endcase
    end

    // line store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte)
        begin
            store_mem[fill_reg] <= rx_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= store_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            end_reg       <= '0;
            rd_idx_reg    <= '0;
            rep_reg       <= tnorla_pkg::RS_IAC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.fill_clr)
            begin
                fill_reg   <= '0;
                end_reg    <= fill_reg;
                rd_idx_reg <= '0;
            end
            else if (cmd.fill_inc)
            begin
                fill_reg <= fill_reg + tnorla_pkg::IDX_W'(1);
            end

            if (cmd.out_load && cmd.out_sel == tnorla_pkg::OUT_LINE)
            begin
                rd_idx_reg <= rd_idx_reg + tnorla_pkg::IDX_W'(1);
            end

            if (cmd.opt_load)
            begin
                rep_reg <= tnorla_pkg::RS_IAC;
            end
            else if (cmd.out_load && cmd.out_sel == tnorla_pkg::OUT_REPLY)
            begin
                rep_reg <= tnorla_pkg::rep_step_t'(2'(rep_reg + 2'd1));
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.opt_load)
        begin
            opt_reg  <= rx_byte;
            code_reg <= cmd.code_dont ? tnorla_pkg::TN_DONT : tnorla_pkg::TN_WONT;
        end
        if (cmd.out_load)
        begin
            out_kind_reg <= next_kind;
            out_byte_reg <= next_byte;
            out_last_reg <= next_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hdl/tnorla_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnorla_ctrl
// Controller: IAC parse state and the sequencer that accepts bytes, walks
// reply runs and reads completed lines out of the store.
// ----------------------------------------------------------------------------
module tnorla_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tnorla_pkg::dp_status_t sts,
    output tnorla_pkg::ctrl_cmd_t  cmd
);

    tnorla_pkg::ctrl_state_t  state_reg, state_next;
    tnorla_pkg::parse_state_t parse_reg, parse_next;

    logic accept;
    logic data_take;
    logic line_end;
    logic reply_go;
    logic reply_dont;

    assign in_ready = (state_reg == tnorla_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    // byte decode against the current parse state
    always_comb
    begin
        data_take  = 1'b0;
        reply_go   = 1'b0;
        reply_dont = 1'b0;
        case (parse_reg)
            tnorla_pkg::PS_IAC:
            begin
                data_take = sts.is_iac;
            end
            tnorla_pkg::PS_WILL, tnorla_pkg::PS_WONT:
            begin
                reply_go   = 1'b1;
                reply_dont = 1'b1;
            end
            tnorla_pkg::PS_DO, tnorla_pkg::PS_DONT:
            begin
                reply_go = 1'b1;
            end
            default:
            begin
                data_take = !sts.is_iac;
            end
        endcase
        data_take = accept && data_take && !sts.is_cr;
        reply_go  = accept && reply_go;
        line_end  = data_take && (sts.is_nl || sts.fill_last);
    end

    always_comb
    begin
        state_next = state_reg;
        parse_next = parse_reg;
        if (accept)
        begin
            case (parse_reg)
                tnorla_pkg::PS_IAC:
                begin
                    if (sts.is_will)
                        parse_next = tnorla_pkg::PS_WILL;
                    else if (sts.is_wont)
                        parse_next = tnorla_pkg::PS_WONT;
                    else if (sts.is_do)
                        parse_next = tnorla_pkg::PS_DO;
                    else if (sts.is_dont)
                        parse_next = tnorla_pkg::PS_DONT;
                    else
                        parse_next = tnorla_pkg::PS_NORMAL;
                end
                tnorla_pkg::PS_NORMAL:
                begin
                    parse_next = sts.is_iac ? tnorla_pkg::PS_IAC : tnorla_pkg::PS_NORMAL;
                end
                default:
                begin
                    parse_next = tnorla_pkg::PS_NORMAL;
                end
            endcase
        end

        case (state_reg)
            tnorla_pkg::ST_IDLE:
            begin
                if (reply_go)
                    state_next = tnorla_pkg::ST_REPLY;
                else if (line_end)
                    state_next = sts.fill_zero ? tnorla_pkg::ST_NL : tnorla_pkg::ST_LINE_RD;
            end
            tnorla_pkg::ST_REPLY:
            begin
                if (sts.out_free && sts.rep_last)
                    state_next = tnorla_pkg::ST_IDLE;
            end
            tnorla_pkg::ST_NL:
            begin
                if (sts.out_free)
                    state_next = tnorla_pkg::ST_IDLE;
            end
            tnorla_pkg::ST_LINE_RD:
            begin
                state_next = tnorla_pkg::ST_LINE_LD;
            end
            tnorla_pkg::ST_LINE_LD:
            begin
                if (sts.out_free)
                    state_next = sts.rd_last ? tnorla_pkg::ST_IDLE : tnorla_pkg::ST_LINE_RD;
            end
            default:
            begin
                state_next = tnorla_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.out_sel   = tnorla_pkg::OUT_LINE;
        case (state_reg)
            tnorla_pkg::ST_IDLE:
            begin
                cmd.wr_byte   = data_take;
                cmd.fill_clr  = line_end;
                cmd.fill_inc  = data_take && !line_end;
                cmd.opt_load  = reply_go;
                cmd.code_dont = reply_dont;
            end
            tnorla_pkg::ST_REPLY:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_sel  = tnorla_pkg::OUT_REPLY;
            end
            tnorla_pkg::ST_NL:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_sel  = tnorla_pkg::OUT_NL;
            end
            tnorla_pkg::ST_LINE_RD:
            begin
                cmd.rd_issue = 1'b1;
            end
            tnorla_pkg::ST_LINE_LD:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd.out_sel = tnorla_pkg::OUT_LINE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tnorla_pkg::ST_IDLE;
            parse_reg <= tnorla_pkg::PS_NORMAL;
        end
        else
        begin
            state_reg <= state_next;
            parse_reg <= parse_next;
        end
    end

    // a word is only loaded when the output register can take it
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output word loaded while register still full");

    // store writes and reply latch loads happen only on an accepted byte
    a_wr_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_byte || cmd.opt_load) |-> (in_valid && state_reg == tnorla_pkg::ST_IDLE))
        else $error("store or reply latch updated without an accepted byte");

    // final line word returns the sequencer to idle
    a_line_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tnorla_pkg::ST_LINE_LD && cmd.out_load && sts.rd_last)
        |=> state_reg == tnorla_pkg::ST_IDLE)
        else $error("line run did not end after its last word");

    // a reply always starts from its first byte
    a_reply_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tnorla_pkg::ST_IDLE && reply_go) |=> !sts.rep_last)
        else $error("reply run started at the wrong step");

endmodule
